FILE: rtl/tto_pkg.sv
// Shared types, constants and helpers for the trinomial tree option pricer.
package tto_pkg;

	localparam int PRICE_W  = 32;
	localparam int FACTOR_W = 18;
	localparam int COEF_W   = 17;
	localparam int LEVEL_W  = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 51;

	localparam int MAX_LEVELS_DEF = 64;

	localparam logic [PRICE_W-1:0]  SPOT_RST  = 32'd6553600;
	localparam logic [FACTOR_W-1:0] UP_RST    = 18'd65536;
	localparam logic [FACTOR_W-1:0] DOWN_RST  = 18'd65536;
	localparam logic [COEF_W-1:0]   PU_RST    = 17'd21845;
	localparam logic [COEF_W-1:0]   PM_RST    = 17'd21846;
	localparam logic [COEF_W-1:0]   PD_RST    = 17'd21845;
	localparam logic [COEF_W-1:0]   DISC_RST  = 17'd65536;
	localparam logic [LEVEL_W-1:0]  LEVEL_RST = 7'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPOT  = 3'd0,
		REG_UP    = 3'd1,
		REG_DOWN  = 3'd2,
		REG_PU    = 3'd3,
		REG_PM    = 3'd4,
		REG_PD    = 3'd5,
		REG_DISC  = 3'd6,
		REG_LEVEL = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [PRICE_W-1:0]  spot_price;
		logic [FACTOR_W-1:0] up_factor;
		logic [FACTOR_W-1:0] down_factor;
		logic [COEF_W-1:0]   prob_up;
		logic [COEF_W-1:0]   prob_mid;
		logic [COEF_W-1:0]   prob_down;
		logic [COEF_W-1:0]   discount;
		logic [LEVEL_W-1:0]  level_count;
	} cfg_t;

	function automatic logic [PRICE_W-1:0] call_payoff(input logic [PRICE_W-1:0] price,
		input logic [PRICE_W-1:0] strike);
		call_payoff = (price > strike) ? (price - strike) : '0;
	endfunction

endpackage

FILE: rtl/tto_if.sv
// Valid/ready channel interfaces for strike requests and priced results.
interface tto_req_if;
	import tto_pkg::*;
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] strike;
	modport source (output valid, output strike, input ready);
	modport sink (input valid, input strike, output ready);
endinterface

interface tto_rsp_if;
	import tto_pkg::*;
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] option_value;
	logic               overflow;
	modport source (output valid, output option_value, output overflow, input ready);
	modport sink (input valid, input option_value, input overflow, output ready);
endinterface

FILE: rtl/tto_cfg.sv
// Configuration register bank for the tree coefficients and level count.
module tto_cfg
	import tto_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spot_price  <= SPOT_RST;
			cfg_q.up_factor   <= UP_RST;
			cfg_q.down_factor <= DOWN_RST;
			cfg_q.prob_up     <= PU_RST;
			cfg_q.prob_mid    <= PM_RST;
			cfg_q.prob_down   <= PD_RST;
			cfg_q.discount    <= DISC_RST;
			cfg_q.level_count <= LEVEL_RST;
		end else if (we) begin
			case (cfg_idx_t'(index))
				REG_SPOT:  cfg_q.spot_price  <= data[PRICE_W-1:0];
				REG_UP:    cfg_q.up_factor   <= data[FACTOR_W-1:0];
				REG_DOWN:  cfg_q.down_factor <= data[FACTOR_W-1:0];
				REG_PU:    cfg_q.prob_up     <= data[COEF_W-1:0];
				REG_PM:    cfg_q.prob_mid    <= data[COEF_W-1:0];
				REG_PD:    cfg_q.prob_down   <= data[COEF_W-1:0];
				REG_DISC:  cfg_q.discount    <= data[COEF_W-1:0];
				REG_LEVEL: cfg_q.level_count <= data[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/tto_mul.sv
// Shared unsigned multiplier with a registered product.
module tto_mul
	import tto_pkg::*;
(
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p
);

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

FILE: rtl/tto_mem.sv
// Node value memory: one write port, one read port with registered data.
module tto_mem
	import tto_pkg::*;
#(
	parameter int DEPTH = 2 * MAX_LEVELS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [PRICE_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [PRICE_W-1:0] rdata
);

	logic [PRICE_W-1:0] mem [DEPTH];
	logic [PRICE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/trinomial_tree_option_pricer.sv
// Trinomial tree European call pricer: sequencer, datapath and assertions.
// Not ready for a new strike while an item is in flight.
// Terminal nodes step S_TMUL, S_TWR; interior nodes S_PU through S_WR; each row loads in S_LD.
// A result still waiting at the output holds the sequencer in its done state.
// Reset clears control and configuration to defaults; node memory is not cleared.
module trinomial_tree_option_pricer
	import tto_pkg::*;
#(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tto_req_if.sink               req,
	tto_rsp_if.source             rsp
);

	localparam int DEPTH = 2 * MAX_LEVELS;
	localparam int IW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_TMUL, S_TWR, S_LD, S_PU, S_PM, S_PD, S_SUM, S_DSC, S_WR, S_DONE
	} state_t;

	cfg_t cfg;

	state_t             state_q;
	logic [PRICE_W-1:0] strike_q;
	logic [PRICE_W-1:0] cur_q;
	logic [IW-1:0]      j_q;
	logic [IW-1:0]      lvl_q;
	logic [IW-1:0]      mid_q;
	logic [IW-1:0]      last_q;
	logic               down_q;
	logic [1:0]         ld_q;
	logic [PRICE_W-1:0] w0_q, w1_q, w2_q;
	logic [ACC_W-1:0]   acc_q;
	logic               ovf_q;
	logic [PRICE_W-1:0] res_q;
	logic               rsp_valid_q;
	logic [PRICE_W-1:0] rsp_value_q;
	logic               rsp_ovf_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	logic               sat_o;
	logic [PRICE_W-1:0] sat_v;
	logic [31:0]        lc32;
	logic [31:0]        lv32;
	logic [IW-1:0]      mid_n;
	logic [IW-1:0]      jend;
	logic               mem_we, mem_re;
	logic [IW-1:0]      mem_waddr, mem_raddr;
	logic [PRICE_W-1:0] mem_wdata, mem_rdata;

	tto_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tto_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	tto_mem #(
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign sat_o = |prod[MUL_P_W-1:48];
	assign sat_v = sat_o ? '1 : prod[47:16];

	always_comb begin
		lc32 = 32'(cfg.level_count);
		if (lc32 == 32'd0) begin
			lv32 = 32'd1;
		end else if (lc32 > 32'(MAX_LEVELS)) begin
			lv32 = 32'(MAX_LEVELS);
		end else begin
			lv32 = lc32;
		end
		mid_n = IW'(lv32 - 32'd1);
	end

	assign jend = {lvl_q[IW-2:0], 1'b0} - IW'(2);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TMUL: begin
				mul_a = MUL_A_W'(cur_q);
				mul_b = down_q ? cfg.down_factor : cfg.up_factor;
			end
			S_PU: begin
				mul_a = MUL_A_W'(w0_q);
				mul_b = MUL_B_W'(cfg.prob_up);
			end
			S_PM: begin
				mul_a = MUL_A_W'(w1_q);
				mul_b = MUL_B_W'(cfg.prob_mid);
			end
			S_PD: begin
				mul_a = MUL_A_W'(w2_q);
				mul_b = MUL_B_W'(cfg.prob_down);
			end
			S_DSC: begin
				mul_a = acc_q[ACC_W-1:16];
				mul_b = MUL_B_W'(cfg.discount);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = j_q;
		mem_wdata = sat_v;
		mem_re    = 1'b0;
		mem_raddr = IW'(ld_q);
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = mid_q;
				mem_wdata = call_payoff(cfg.spot_price, strike_q);
			end
			S_TWR: begin
				mem_we    = 1'b1;
				mem_wdata = call_payoff(sat_v, strike_q);
			end
			S_WR: begin
				mem_we = 1'b1;
			end
			S_LD: begin
				mem_re = (ld_q != 2'd3);
			end
			S_PU: begin
				mem_re    = 1'b1;
				mem_raddr = j_q + IW'(3);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_value_q <= '0;
			rsp_ovf_q   <= 1'b0;
			down_q      <= 1'b0;
			ld_q        <= '0;
			ovf_q       <= 1'b0;
			j_q         <= '0;
			lvl_q       <= '0;
			mid_q       <= '0;
			last_q      <= '0;
			strike_q    <= '0;
			cur_q       <= '0;
			w0_q        <= '0;
			w1_q        <= '0;
			w2_q        <= '0;
			acc_q       <= '0;
			res_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						strike_q <= req.strike;
						mid_q    <= mid_n;
						last_q   <= {mid_n[IW-2:0], 1'b0};
						ovf_q    <= 1'b0;
						state_q  <= S_INIT;
					end
				end
				S_INIT: begin
					cur_q <= cfg.spot_price;
					if (mid_q == '0) begin
						res_q   <= call_payoff(cfg.spot_price, strike_q);
						state_q <= S_DONE;
					end else begin
						j_q     <= mid_q - IW'(1);
						down_q  <= 1'b0;
						state_q <= S_TMUL;
					end
				end
				S_TMUL: begin
					state_q <= S_TWR;
				end
				S_TWR: begin
					cur_q <= sat_v;
					ovf_q <= ovf_q | sat_o;
					state_q <= S_TMUL;
					if (!down_q) begin
						if (j_q == '0) begin
							cur_q  <= cfg.spot_price;
							j_q    <= mid_q + IW'(1);
							down_q <= 1'b1;
						end else begin
							j_q <= j_q - IW'(1);
						end
					end else if (j_q == last_q) begin
						lvl_q   <= mid_q;
						j_q     <= '0;
						ld_q    <= '0;
						state_q <= S_LD;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				S_LD: begin
					if (ld_q != 2'd0) begin
						w0_q <= w1_q;
						w1_q <= w2_q;
						w2_q <= mem_rdata;
					end
					ld_q <= ld_q + 2'd1;
					if (ld_q == 2'd3) begin
						state_q <= S_PU;
					end
				end
				S_PU: begin
					state_q <= S_PM;
				end
				S_PM: begin
					acc_q   <= prod[ACC_W-1:0];
					state_q <= S_PD;
				end
				S_PD: begin
					acc_q   <= acc_q + prod[ACC_W-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + prod[ACC_W-1:0];
					state_q <= S_DSC;
				end
				S_DSC: begin
					state_q <= S_WR;
				end
				S_WR: begin
					ovf_q <= ovf_q | sat_o;
					w0_q  <= w1_q;
					w1_q  <= w2_q;
					w2_q  <= mem_rdata;
					if (j_q == jend) begin
						if (lvl_q == IW'(1)) begin
							res_q   <= sat_v;
							state_q <= S_DONE;
						end else begin
							lvl_q   <= lvl_q - IW'(1);
							j_q     <= '0;
							ld_q    <= '0;
							state_q <= S_LD;
						end
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_PU;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_value_q <= res_q;
						rsp_ovf_q   <= ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.option_value = rsp_value_q;
	assign rsp.overflow     = rsp_ovf_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("pricer accepted an item while busy");

	a_write_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != S_IDLE |-> mem_waddr <= last_q)
		else $error("node write beyond the terminal row");

	a_row_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PU |-> lvl_q != '0 && j_q <= jend)
		else $error("backward node index outside its row");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done state");

endmodule

FILE: tb/trinomial_tree_option_pricer_tb.sv
`timescale 1ns / 100ps
// Testbench for the trinomial tree call pricer: directed table, then random configs and strikes.
module trinomial_tree_option_pricer_tb;
	import tto_pkg::*;

	localparam int MAX_LEVELS    = MAX_LEVELS_DEF;
	localparam int STALL_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 100;
	localparam int TAIL_CYCLES   = 64;
	localparam int DIRECTED_ROWS = 36;
	localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct {
		logic [PRICE_W-1:0] option_value;
		logic               overflow;
	} call_quote_t;

	typedef struct {
		row_kind_t             kind;
		cfg_idx_t              index;
		logic [CFG_DATA_W-1:0] data;
		bit                    known;
		logic [PRICE_W-1:0]    option_value;
		logic                  overflow;
	} stim_row_t;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_ITEM,  REG_SPOT,  32'd0,         1'b1, 32'd6553600, 1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'hFFFF_FFFF, 1'b1, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd6553600,   1'b1, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd6553599,   1'b1, 32'd1,       1'b0},
		'{ROW_WRITE, REG_LEVEL, 32'd0,         1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd100,       1'b1, 32'd6553500, 1'b0},
		'{ROW_WRITE, REG_UP,    32'd66250,     1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_DOWN,  32'd64828,     1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_PU,    32'd16384,     1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_PM,    32'd32768,     1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_PD,    32'd16384,     1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_DISC,  32'd65470,     1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_LEVEL, 32'd5,         1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd6553600,   1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd6000000,   1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd0,         1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'hFFFF_FFFF, 1'b1, 32'd0,       1'b0},
		'{ROW_WRITE, REG_LEVEL, 32'h7F,        1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd6553600,   1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_SPOT,  32'hFFFF_FFFF, 1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_UP,    32'hFFFF_FFFF, 1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_LEVEL, 32'd2,         1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd0,         1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_PU,    32'hFFFF_FFFF, 1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_PM,    32'hFFFF_FFFF, 1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_PD,    32'hFFFF_FFFF, 1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_DISC,  32'hFFFF_FFFF, 1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd0,         1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'h8000_0000, 1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_UP,    32'd0,         1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_DOWN,  32'd0,         1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_SPOT,  32'h1234_5678, 1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_LEVEL, 32'd3,         1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd0,         1'b0, 32'd0,       1'b0},
		'{ROW_WRITE, REG_SPOT,  32'd0,         1'b0, 32'd0,       1'b0},
		'{ROW_ITEM,  REG_SPOT,  32'd0,         1'b1, 32'd0,       1'b0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tto_req_if req_ch ();
	tto_rsp_if rsp_ch ();

	cfg_t        pricer_cfg;
	call_quote_t priced_q [$];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatches    = 0;
	int          stall_cycles  = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	trinomial_tree_option_pricer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	function automatic logic [PRICE_W-1:0] sat_q16(input logic [63:0] x, inout bit ovf);
		logic [63:0] r;
		r = x >> 16;
		if (r > 64'(PRICE_MAX)) begin
			ovf = 1'b1;
			return PRICE_MAX;
		end
		return r[PRICE_W-1:0];
	endfunction

	function automatic call_quote_t price_call(input logic [PRICE_W-1:0] strike);
		logic [PRICE_W-1:0] nodes [2*MAX_LEVELS];
		logic [63:0]        acc;
		int                 levels;
		int                 mid;
		int                 last;
		bit                 ovf;
		call_quote_t        quote;
		ovf = 1'b0;
		levels = int'(pricer_cfg.level_count);
		if (levels == 0)
			levels = 1;
		if (levels > MAX_LEVELS)
			levels = MAX_LEVELS;
		mid = levels - 1;
		last = 2 * levels - 2;
		nodes[mid] = pricer_cfg.spot_price;
		for (int j = mid; j > 0; j--) begin
			acc = nodes[j] * pricer_cfg.up_factor;
			nodes[j-1] = sat_q16(acc, ovf);
		end
		for (int j = mid + 1; j <= last; j++) begin
			acc = nodes[j-1] * pricer_cfg.down_factor;
			nodes[j] = sat_q16(acc, ovf);
		end
		for (int j = 0; j <= last; j++)
			nodes[j] = (nodes[j] > strike) ? nodes[j] - strike : '0;
		for (int i = mid; i > 0; i--) begin
			for (int j = 0; j < 2 * i - 1; j++) begin
				acc = pricer_cfg.prob_up * nodes[j] + pricer_cfg.prob_mid * nodes[j+1]
					+ pricer_cfg.prob_down * nodes[j+2];
				acc = (acc >> 16) * pricer_cfg.discount;
				nodes[j] = sat_q16(acc, ovf);
			end
		end
		quote.option_value = nodes[0];
		quote.overflow = ovf;
		return quote;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SPOT:  pricer_cfg.spot_price  = data[PRICE_W-1:0];
			REG_UP:    pricer_cfg.up_factor   = data[FACTOR_W-1:0];
			REG_DOWN:  pricer_cfg.down_factor = data[FACTOR_W-1:0];
			REG_PU:    pricer_cfg.prob_up     = data[COEF_W-1:0];
			REG_PM:    pricer_cfg.prob_mid    = data[COEF_W-1:0];
			REG_PD:    pricer_cfg.prob_down   = data[COEF_W-1:0];
			REG_DISC:  pricer_cfg.discount    = data[COEF_W-1:0];
			REG_LEVEL: pricer_cfg.level_count = data[LEVEL_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_strike(input logic [PRICE_W-1:0] strike, input bit known,
		input logic [PRICE_W-1:0] known_value, input logic known_ovf);
		call_quote_t quote;
		cfg_we <= 1'b0;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.strike <= strike;
		if (known) begin
			quote.option_value = known_value;
			quote.overflow = known_ovf;
		end else begin
			quote = price_call(strike);
		end
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		priced_q = {priced_q, quote};
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (priced_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		call_quote_t want;
		rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (priced_q.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result: expected none actual %h overflow %b",
						$time, rsp_ch.option_value, rsp_ch.overflow);
				end else begin
					want = priced_q.pop_front();
					if (rsp_ch.option_value !== want.option_value) begin
						mismatches++;
						$display("%0t option_value mismatch: expected %h actual %h",
							$time, want.option_value, rsp_ch.option_value);
					end
					if (rsp_ch.overflow !== want.overflow) begin
						mismatches++;
						$display("%0t overflow mismatch: expected %b actual %b",
							$time, want.overflow, rsp_ch.overflow);
					end
				end
			end
		end
	end

	initial begin
		stim_row_t          row;
		bit                 writing;
		int                 sent;
		int                 batch;
		int unsigned        pick;
		int unsigned        up;
		int unsigned        pu;
		int unsigned        pd;
		logic [63:0]        hi;
		logic [PRICE_W-1:0] strike;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.strike = '0;
		pricer_cfg = '{SPOT_RST, UP_RST, DOWN_RST, PU_RST, PM_RST, PD_RST, DISC_RST, LEVEL_RST};
		send_idle_pct = 20;
		recv_idle_pct = 50;
		writing = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			row = directed_rows[r];
			if (row.kind == ROW_WRITE) begin
				if (!writing)
					drain_results();
				writing = 1'b1;
				write_reg(row.index, row.data);
			end else begin
				writing = 1'b0;
				send_strike(row.data, row.known, row.option_value, row.overflow);
			end
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 20;
				recv_idle_pct = 50;
			end else if (sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 50;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain_results();
			if ($urandom_range(3, 0) == 0) begin
				write_reg(REG_SPOT, $urandom);
				write_reg(REG_UP, $urandom);
				write_reg(REG_DOWN, $urandom);
				write_reg(REG_PU, $urandom);
				write_reg(REG_PM, $urandom);
				write_reg(REG_PD, $urandom);
				write_reg(REG_DISC, $urandom);
			end else begin
				up = $urandom_range(75000, 65536);
				pu = $urandom_range(30000, 8000);
				pd = $urandom_range(30000, 8000);
				write_reg(REG_SPOT, $urandom_range(32'h0400_0000, 32'h0010_0000));
				write_reg(REG_UP, up);
				write_reg(REG_DOWN, CFG_DATA_W'(64'h1_0000_0000 / up));
				write_reg(REG_PU, pu);
				write_reg(REG_PM, 65536 - pu - pd);
				write_reg(REG_PD, pd);
				write_reg(REG_DISC, $urandom_range(65536, 62000));
			end
			pick = $urandom_range(99, 0);
			if (pick < 4)
				write_reg(REG_LEVEL, $urandom_range(127, 64));
			else if (pick < 25)
				write_reg(REG_LEVEL, $urandom_range(20, 9));
			else
				write_reg(REG_LEVEL, $urandom_range(8, 0));
			batch = $urandom_range(10, 6);
			repeat (batch) begin
				if ($urandom_range(3, 0) == 0) begin
					strike = $urandom;
				end else begin
					hi = pricer_cfg.spot_price + (pricer_cfg.spot_price >> 1);
					if (hi > 64'(PRICE_MAX))
						hi = 64'(PRICE_MAX);
					strike = $urandom_range(hi[31:0], pricer_cfg.spot_price >> 1);
				end
				send_strike(strike, 1'b0, '0, 1'b0);
				sent++;
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/tto_pkg.sv
rtl/tto_if.sv
rtl/tto_cfg.sv
rtl/tto_mul.sv
rtl/tto_mem.sv
rtl/trinomial_tree_option_pricer.sv
tb/trinomial_tree_option_pricer_tb.sv
